### sv/fvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Follow velocity controller package
// Field widths, register indexes, opcodes, fixed Q10 constants and the
// structures shared by the controller modules.
// ----------------------------------------------------------------------------
package fvc_pkg;

  // Channel field widths.
  localparam int OPCODE_W   = 2;
  localparam int BEARING_W  = 13;
  localparam int RANGE_W    = 14;
  localparam int MODE_W     = 8;
  localparam int VEL_W      = 12;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  // Register widths.
  localparam int DIST_W    = 14;
  localparam int GAIN_W    = 12;
  localparam int LIMIT_W   = 11;
  localparam int TICKS_W   = 8;

  // Fixed Q10 constants of the control law.
  localparam int DIST_DEADBAND        = 154;
  localparam int BEARING_DEADBAND     = 51;
  localparam int FORWARD_MIN          = -307;
  localparam int MIN_SAFE_RANGE       = 614;
  localparam int OFF_AXIS_BEARING     = 410;
  localparam int OFF_AXIS_FORWARD_CAP = 102;
  localparam int FORWARD_OUT_DEADBAND = 82;
  localparam int YAW_OUT_DEADBAND     = 102;

  // Input opcodes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_TARGET = 2'd0,
    OP_MODE   = 2'd1,
    OP_TICK   = 2'd2
  } opcode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DESIRED_DISTANCE    = 8'd0,
    REG_DISTANCE_GAIN       = 8'd1,
    REG_YAW_GAIN            = 8'd2,
    REG_FORWARD_SPEED_LIMIT = 8'd3,
    REG_YAW_RATE_LIMIT      = 8'd4,
    REG_FORWARD_SLEW_STEP   = 8'd5,
    REG_YAW_SLEW_STEP       = 8'd6,
    REG_TIMEOUT_TICKS       = 8'd7
  } cfg_reg_t;

  // Configuration register file.
  typedef struct packed {
    logic [DIST_W-1:0]  desired_distance;
    logic [GAIN_W-1:0]  distance_gain;
    logic [GAIN_W-1:0]  yaw_gain;
    logic [LIMIT_W-1:0] forward_speed_limit;
    logic [LIMIT_W-1:0] yaw_rate_limit;
    logic [LIMIT_W-1:0] forward_slew_step;
    logic [LIMIT_W-1:0] yaw_slew_step;
    logic [TICKS_W-1:0] timeout_ticks;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    desired_distance:    14'd1536,
    distance_gain:       12'd205,
    yaw_gain:            12'd640,
    forward_speed_limit: 11'd819,
    yaw_rate_limit:      11'd1229,
    forward_slew_step:   11'd77,
    yaw_slew_step:       11'd154,
    timeout_ticks:       8'd10
  };

  // Controller state seen by the control law.
  typedef struct packed {
    logic signed [BEARING_W-1:0] smoothed_bearing;
    logic [RANGE_W-1:0]          smoothed_range;
    logic signed [VEL_W-1:0]     last_forward;
    logic signed [VEL_W-1:0]     last_yaw;
  } follow_state_t;

  // Velocity command produced by the control law.
  typedef struct packed {
    logic signed [VEL_W-1:0] forward;
    logic signed [VEL_W-1:0] yaw;
  } vel_cmd_t;

endpackage

### sv/fvc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Follow velocity controller channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------

// Input item channel.
interface fvc_in_if;
  import fvc_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [OPCODE_W-1:0]         opcode;
  logic signed [BEARING_W-1:0] bearing;
  logic [RANGE_W-1:0]          range_to_target;
  logic [MODE_W-1:0]           mode_value;

  modport source (output valid, opcode, bearing, range_to_target, mode_value,
                  input ready);
  modport sink (input valid, opcode, bearing, range_to_target, mode_value,
                output ready);
endinterface

// Result item channel.
interface fvc_out_if;
  import fvc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    stop_command;
  logic signed [VEL_W-1:0] forward_velocity;
  logic signed [VEL_W-1:0] yaw_velocity;

  modport source (output valid, stop_command, forward_velocity, yaw_velocity,
                  input ready);
  modport sink (input valid, stop_command, forward_velocity, yaw_velocity,
                output ready);
endinterface

// Register write channel.
interface fvc_cfg_if;
  import fvc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

### sv/fvc_target_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target smoothing filter
// Loads a fresh bearing and range when the target is stale, otherwise blends
// them as (2*new + 3*old) / 5, rounded to nearest.
// ----------------------------------------------------------------------------
module fvc_target_filter (
  input  logic                                stale,
  input  logic signed [fvc_pkg::BEARING_W-1:0] fresh_bearing,
  input  logic [fvc_pkg::RANGE_W-1:0]          fresh_range,
  input  logic signed [fvc_pkg::BEARING_W-1:0] old_bearing,
  input  logic [fvc_pkg::RANGE_W-1:0]          old_range,
  output logic signed [fvc_pkg::BEARING_W-1:0] new_bearing,
  output logic [fvc_pkg::RANGE_W-1:0]          new_range
);
  import fvc_pkg::*;

  // Width of the dividend and quotient of the divide-by-ten.
  localparam int DIV_IN_W  = 18;
  localparam int DIV_Q_W   = 15;
  localparam int DIV_SHIFT = 21;
  // Reciprocal of ten scaled by 2**21, rounded up; exact below 2**18.
  localparam logic [DIV_IN_W-1:0] DIV_RECIP = 18'd209716;
  // Bias that keeps the bearing dividend positive: ten times BIAS_Q.
  localparam int BIAS_Q = 4100;

  // Divide an unsigned value by ten using the scaled reciprocal.
  function automatic logic [DIV_Q_W-1:0] div10(input logic [DIV_IN_W-1:0] x);
    logic [2*DIV_IN_W-1:0] prod;
    prod = x * DIV_RECIP;
    return prod[DIV_SHIFT +: DIV_Q_W];
  endfunction

  logic signed [DIV_IN_W-1:0] brg_num;
  logic [DIV_Q_W-1:0]         brg_q;
  logic signed [DIV_Q_W-1:0]  brg_blend;
  logic [DIV_IN_W-1:0]        rng_num;
  logic [DIV_Q_W-1:0]         rng_q;

  // Bearing: 2*(2*new + 3*old) + 5 with a bias so the floor divide is unsigned.
  assign brg_num = 18'(4 * fresh_bearing) + 18'(6 * old_bearing)
                 + 18'(5 + 10 * BIAS_Q);
  assign brg_q     = div10(brg_num);
  assign brg_blend = $signed(brg_q) - DIV_Q_W'(BIAS_Q);

  // Range: the same rounding, always positive.
  assign rng_num = (DIV_IN_W'(fresh_range) << 2)
                 + DIV_IN_W'(old_range) * 18'd6 + 18'd5;
  assign rng_q   = div10(rng_num);

  // Select between loading and blending.
  assign new_bearing = stale ? fresh_bearing : brg_blend[BEARING_W-1:0];
  assign new_range   = stale ? fresh_range : rng_q[RANGE_W-1:0];

endmodule

### sv/fvc_drive_law.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Follow control law
// Proportional forward and yaw commands with deadbands, clamps, a minimum
// safe range, an off-axis forward cap, slew limits and output deadbands.
// ----------------------------------------------------------------------------
module fvc_drive_law (
  input  fvc_pkg::cfg_regs_t     cfg,
  input  fvc_pkg::follow_state_t st,
  output fvc_pkg::vel_cmd_t      cmd
);
  import fvc_pkg::*;

  localparam int ERR_W   = RANGE_W + 1;
  localparam int DPROD_W = GAIN_W + 1 + ERR_W;
  localparam int DSCL_W  = DPROD_W - 8;
  localparam int NBRG_W  = BEARING_W + 1;
  localparam int YPROD_W = GAIN_W + 1 + NBRG_W;
  localparam int YSCL_W  = YPROD_W - 8;
  localparam int SLEW_W  = VEL_W + 2;

  logic signed [ERR_W-1:0]   range_err;
  logic [ERR_W-1:0]          range_err_abs;
  logic signed [DPROD_W-1:0] dist_sum;
  logic signed [DSCL_W-1:0]  dist_scaled;
  logic signed [DSCL_W-1:0]  fwd_max;
  logic signed [VEL_W-1:0]   vx_gain;
  logic signed [VEL_W-1:0]   vx_safe;
  logic signed [VEL_W-1:0]   vx_cap;
  logic [BEARING_W-1:0]      brg_abs;
  logic signed [NBRG_W-1:0]  brg_neg;
  logic signed [YPROD_W-1:0] yaw_sum;
  logic signed [YSCL_W-1:0]  yaw_scaled;
  logic signed [YSCL_W-1:0]  yaw_max;
  logic signed [VEL_W-1:0]   vyaw_gain;
  logic signed [SLEW_W-1:0]  fwd_lo;
  logic signed [SLEW_W-1:0]  fwd_hi;
  logic signed [SLEW_W-1:0]  yaw_lo;
  logic signed [SLEW_W-1:0]  yaw_hi;
  logic signed [SLEW_W-1:0]  vx_ext;
  logic signed [SLEW_W-1:0]  vyaw_ext;
  logic signed [VEL_W-1:0]   vx_slew;
  logic signed [VEL_W-1:0]   vyaw_slew;

  // Distance error and its gain term, rounded half up.
  assign range_err     = $signed({1'b0, st.smoothed_range})
                       - $signed({1'b0, cfg.desired_distance});
  assign range_err_abs = range_err[ERR_W-1] ? ERR_W'(-range_err) : ERR_W'(range_err);
  assign dist_sum      = $signed({1'b0, cfg.distance_gain}) * range_err
                       + DPROD_W'(128);
  assign dist_scaled   = dist_sum[DPROD_W-1:8];
  assign fwd_max       = $signed(DSCL_W'(cfg.forward_speed_limit));

  // Forward term: deadband, clamp and minimum safe range.
  always_comb begin
    vx_gain = '0;
    if (range_err_abs > ERR_W'(DIST_DEADBAND)) begin
      if (dist_scaled < DSCL_W'(FORWARD_MIN)) begin
        vx_gain = VEL_W'(FORWARD_MIN);
      end else if (dist_scaled > fwd_max) begin
        vx_gain = VEL_W'(fwd_max);
      end else begin
        vx_gain = dist_scaled[VEL_W-1:0];
      end
    end
    vx_safe = vx_gain;
    if ((st.smoothed_range < RANGE_W'(MIN_SAFE_RANGE)) && (vx_gain > 0)) begin
      vx_safe = '0;
    end
  end

  // Yaw term on the negated bearing, rounded half up.
  assign brg_abs    = st.smoothed_bearing[BEARING_W-1] ?
                      BEARING_W'(-$signed({st.smoothed_bearing[BEARING_W-1],
                                           st.smoothed_bearing})) :
                      BEARING_W'(st.smoothed_bearing);
  assign brg_neg    = -$signed({st.smoothed_bearing[BEARING_W-1], st.smoothed_bearing});
  assign yaw_sum    = $signed({1'b0, cfg.yaw_gain}) * brg_neg + YPROD_W'(128);
  assign yaw_scaled = yaw_sum[YPROD_W-1:8];
  assign yaw_max    = $signed(YSCL_W'(cfg.yaw_rate_limit));

  always_comb begin
    vyaw_gain = '0;
    if (brg_abs > BEARING_W'(BEARING_DEADBAND)) begin
      if (yaw_scaled < -yaw_max) begin
        vyaw_gain = VEL_W'(-yaw_max);
      end else if (yaw_scaled > yaw_max) begin
        vyaw_gain = VEL_W'(yaw_max);
      end else begin
        vyaw_gain = yaw_scaled[VEL_W-1:0];
      end
    end
  end

  // Cap the forward speed while the target is well off axis.
  always_comb begin
    vx_cap = vx_safe;
    if ((brg_abs > BEARING_W'(OFF_AXIS_BEARING)) &&
        (vx_safe > VEL_W'(OFF_AXIS_FORWARD_CAP))) begin
      vx_cap = VEL_W'(OFF_AXIS_FORWARD_CAP);
    end
  end

  // Slew windows around the previous command.
  assign fwd_lo   = SLEW_W'(st.last_forward) - $signed(SLEW_W'(cfg.forward_slew_step));
  assign fwd_hi   = SLEW_W'(st.last_forward) + $signed(SLEW_W'(cfg.forward_slew_step));
  assign yaw_lo   = SLEW_W'(st.last_yaw) - $signed(SLEW_W'(cfg.yaw_slew_step));
  assign yaw_hi   = SLEW_W'(st.last_yaw) + $signed(SLEW_W'(cfg.yaw_slew_step));
  assign vx_ext   = SLEW_W'(vx_cap);
  assign vyaw_ext = SLEW_W'(vyaw_gain);

  always_comb begin
    if (vx_ext < fwd_lo) begin
      vx_slew = fwd_lo[VEL_W-1:0];
    end else if (vx_ext > fwd_hi) begin
      vx_slew = fwd_hi[VEL_W-1:0];
    end else begin
      vx_slew = vx_cap;
    end
    if (vyaw_ext < yaw_lo) begin
      vyaw_slew = yaw_lo[VEL_W-1:0];
    end else if (vyaw_ext > yaw_hi) begin
      vyaw_slew = yaw_hi[VEL_W-1:0];
    end else begin
      vyaw_slew = vyaw_gain;
    end
  end

  // Output deadbands.
  always_comb begin
    cmd.forward = vx_slew;
    if ((vx_slew > -VEL_W'(FORWARD_OUT_DEADBAND)) &&
        (vx_slew < VEL_W'(FORWARD_OUT_DEADBAND))) begin
      cmd.forward = '0;
    end
    cmd.yaw = vyaw_slew;
    if ((vyaw_slew > -VEL_W'(YAW_OUT_DEADBAND)) &&
        (vyaw_slew < VEL_W'(YAW_OUT_DEADBAND))) begin
      cmd.yaw = '0;
    end
  end

endmodule

### sv/follow_velocity_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Follow velocity controller
// Proportional follow controller with deadbands, clamps and slew limits.
//
// Usage:
//   in_ch carries target updates, mode reports and control ticks. Only a
//   control tick produces a result transaction on out_ch; the other opcodes
//   update internal state, and the unused opcode is dropped.
//   cfg_ch writes the eight control registers; it is ready whenever reset is
//   released. The user must write it only while the block is idle; the block
//   itself does not enforce this. An item passes an input register, then one
//   stage of logic that updates the state and loads the result register. One
//   item is taken every cycle while the stage moves; a tick cannot move while
//   the result register is full and the receiver is not ready. While the
//   receiver stalls, the result register holds its transaction; target and
//   mode items still flow until a tick reaches the input register, where it
//   waits and holds back the items behind it.
//   Reset (rst_n low, synchronous) restores the register defaults, clears the
//   smoothed target, the tick counter, the mode and the slew state, and
//   empties both registers; no channel is ready while it is held.
// ----------------------------------------------------------------------------
module follow_velocity_controller (
  input  logic       clk,
  input  logic       rst_n,
  fvc_in_if.sink     in_ch,
  fvc_out_if.source  out_ch,
  fvc_cfg_if.sink    cfg_ch
);
  import fvc_pkg::*;

  localparam logic [TICKS_W-1:0] TICKS_MAX = '1;

  // Input register.
  logic                        in_valid_r;
  logic [OPCODE_W-1:0]         in_op_r;
  logic signed [BEARING_W-1:0] in_brg_r;
  logic [RANGE_W-1:0]          in_rng_r;
  logic [MODE_W-1:0]           in_mode_r;
  logic                        in_valid_nxt;

  // Controller state.
  cfg_regs_t                   cfg_r;
  follow_state_t               st_r;
  follow_state_t               st_nxt;
  logic [TICKS_W-1:0]          ticks_r;
  logic [TICKS_W-1:0]          ticks_nxt;
  logic                        seen_r;
  logic                        seen_nxt;
  logic [MODE_W-1:0]           mode_r;
  logic [MODE_W-1:0]           mode_nxt;

  // Result register.
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        out_stop_r;
  logic signed [VEL_W-1:0]     out_fwd_r;
  logic signed [VEL_W-1:0]     out_yaw_r;
  logic                        out_stop_nxt;
  logic signed [VEL_W-1:0]     out_fwd_nxt;
  logic signed [VEL_W-1:0]     out_yaw_nxt;

  logic                        in_take;
  logic                        stage_go;
  logic                        out_load;
  logic [TICKS_W-1:0]          ticks_inc;
  logic                        stale_now;
  logic                        stale_tick;
  logic                        mode_unsafe;
  logic signed [BEARING_W-1:0] filt_brg;
  logic [RANGE_W-1:0]          filt_rng;
  vel_cmd_t                    cmd;

  // Handshakes: the stage moves unless a tick finds the result register full and not being taken.
  assign stage_go = in_valid_r &&
                    ((in_op_r != OP_TICK) || !out_valid_r || out_ch.ready);
  assign in_ch.ready = rst_n && (!in_valid_r || stage_go);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = rst_n;
  assign out_load     = stage_go && (in_op_r == OP_TICK);

  assign out_ch.valid            = out_valid_r;
  assign out_ch.stop_command     = out_stop_r;
  assign out_ch.forward_velocity = out_fwd_r;
  assign out_ch.yaw_velocity     = out_yaw_r;

  // Staleness before and after the tick counter advances.
  assign ticks_inc   = (ticks_r == TICKS_MAX) ? ticks_r : ticks_r + 1'b1;
  assign stale_now   = !seen_r || (ticks_r > cfg_r.timeout_ticks);
  assign stale_tick  = !seen_r || (ticks_inc > cfg_r.timeout_ticks);
  assign mode_unsafe = (mode_r == MODE_W'(5)) || (mode_r == MODE_W'(6)) ||
                       (mode_r == MODE_W'(7)) || (mode_r == MODE_W'(8)) ||
                       (mode_r == MODE_W'(10));

  fvc_target_filter u_filter (
    .stale         (stale_now),
    .fresh_bearing (in_brg_r),
    .fresh_range   (in_rng_r),
    .old_bearing   (st_r.smoothed_bearing),
    .old_range     (st_r.smoothed_range),
    .new_bearing   (filt_brg),
    .new_range     (filt_rng)
  );

  fvc_drive_law u_law (
    .cfg (cfg_r),
    .st  (st_r),
    .cmd (cmd)
  );

  // Input register occupancy.
  always_comb begin
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (stage_go) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  // State update for the item in the input register.
  always_comb begin
    st_nxt       = st_r;
    ticks_nxt    = ticks_r;
    seen_nxt     = seen_r;
    mode_nxt     = mode_r;
    out_stop_nxt = out_stop_r;
    out_fwd_nxt  = out_fwd_r;
    out_yaw_nxt  = out_yaw_r;
    if (stage_go) begin
      case (in_op_r)
        OP_TARGET: begin
          st_nxt.smoothed_bearing = filt_brg;
          st_nxt.smoothed_range   = filt_rng;
          ticks_nxt               = '0;
          seen_nxt                = 1'b1;
        end
        OP_MODE: begin
          mode_nxt = in_mode_r;
        end
        OP_TICK: begin
          ticks_nxt = ticks_inc;
          if (mode_unsafe || stale_tick) begin
            st_nxt.last_forward = '0;
            st_nxt.last_yaw     = '0;
            out_stop_nxt        = 1'b1;
            out_fwd_nxt         = '0;
            out_yaw_nxt         = '0;
          end else begin
            st_nxt.last_forward = cmd.forward;
            st_nxt.last_yaw     = cmd.yaw;
            out_stop_nxt        = 1'b0;
            out_fwd_nxt         = cmd.forward;
            out_yaw_nxt         = cmd.yaw;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register occupancy.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= CFG_RESET;
      st_r        <= '0;
      ticks_r     <= '0;
      seen_r      <= 1'b0;
      mode_r      <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
      ticks_r     <= ticks_nxt;
      seen_r      <= seen_nxt;
      mode_r      <= mode_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          REG_DESIRED_DISTANCE:    cfg_r.desired_distance    <= cfg_ch.wdata[DIST_W-1:0];
          REG_DISTANCE_GAIN:       cfg_r.distance_gain       <= cfg_ch.wdata[GAIN_W-1:0];
          REG_YAW_GAIN:            cfg_r.yaw_gain            <= cfg_ch.wdata[GAIN_W-1:0];
          REG_FORWARD_SPEED_LIMIT: cfg_r.forward_speed_limit <= cfg_ch.wdata[LIMIT_W-1:0];
          REG_YAW_RATE_LIMIT:      cfg_r.yaw_rate_limit      <= cfg_ch.wdata[LIMIT_W-1:0];
          REG_FORWARD_SLEW_STEP:   cfg_r.forward_slew_step   <= cfg_ch.wdata[LIMIT_W-1:0];
          REG_YAW_SLEW_STEP:       cfg_r.yaw_slew_step       <= cfg_ch.wdata[LIMIT_W-1:0];
          REG_TIMEOUT_TICKS:       cfg_r.timeout_ticks       <= cfg_ch.wdata[TICKS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op_r   <= in_ch.opcode;
      in_brg_r  <= in_ch.bearing;
      in_rng_r  <= in_ch.range_to_target;
      in_mode_r <= in_ch.mode_value;
    end
    out_stop_r <= out_stop_nxt;
    out_fwd_r  <= out_fwd_nxt;
    out_yaw_r  <= out_yaw_nxt;
  end

endmodule
